// ----- hw/rtl/rhht_pkg.sv -----
// shared types and constants of the robin hood hash table
package rhht_pkg;

   localparam int ENT_W = 11;

   typedef struct packed {
      logic        [1:0]  cmd;
      logic signed [31:0] x_coord;
      logic signed [31:0] z_coord;
      logic        [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      value_out;
      logic [ENT_W-1:0] entries_used;
   } rsp_type;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_MISSING  = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SH = 33;

endpackage

// ----- hw/rtl/rhht_ram.sv -----
// generic simple dual port ram with registered read
module rhht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rhht_front.sv -----
// front end: takes a request word and computes its home slot
module rhht_front import rhht_pkg::*; #(
   parameter int IW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [$bits(req_type)+IW-1:0] push_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        ph_ff, ph_in;
   logic [1:0]  st_ff, st_in;
   req_type     req_ff, req_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] acc_ff, acc_in;

   logic [63:0] key, c, sum, prod;
   logic [31:0] op_a, op_b;
   logic [IW-1:0] home;

   assign key = {req_data.x_coord, req_data.z_coord};
   assign c = ph_ff ? MIX_C2 : MIX_C1;

   // 64x64 low product as three 32x32 partial products
   always_comb begin
      unique case (st_ff)
         2'd0:    begin op_a = k_ff[31:0];  op_b = c[31:0];  end
         2'd1:    begin op_a = k_ff[31:0];  op_b = c[63:32]; end
         default: begin op_a = k_ff[63:32]; op_b = c[31:0];  end
      endcase
   end

   assign prod = op_a * op_b;
   assign sum = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
   assign home = k_ff[IW-1:0];

   always_comb begin
      state_in = state_ff;
      ph_in = ph_ff;
      st_in = st_ff;
      req_in = req_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      req_ready = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = !hold;
            if (req_valid && !hold) begin
               req_in = req_data;
               k_in = key ^ (key >> MIX_SH);
               ph_in = 1'b0;
               st_in = 2'd0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            unique case (st_ff)
               2'd0: begin
                  acc_in = prod;
                  st_in = 2'd1;
               end
               2'd1: begin
                  acc_in = sum;
                  st_in = 2'd2;
               end
               default: begin
                  k_in = sum ^ (sum >> MIX_SH);
                  st_in = 2'd0;
                  ph_in = 1'b1;
                  if (ph_ff) begin
                     state_in = F_PUSH;
                  end
               end
            endcase
         end
         default: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
      endcase
   end

   assign push_data = {home, req_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;
      st_ff <= st_in;
      req_ff <= req_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
   end

endmodule

// ----- hw/rtl/rhht_queue.sv -----
// two word queue between front and back
module rhht_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  logic [W-1:0] push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output logic [W-1:0] pop_data
);

   logic [W-1:0] buf_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data = buf_ff[rp_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wp_ff <= !wp_ff;
         end
         if (do_pop) begin
            rp_ff <= !rp_ff;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wp_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/rhht_back.sv -----
// back end: probes, inserts and removes in the slot memory
module rhht_back import rhht_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   output logic    clearing,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  logic [$bits(req_type)+$clog2(CAPACITY)-1:0] pop_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VAL_LO = 64;
   localparam int DIST_LO = 96;
   localparam int OCC_BIT = 96 + IW;
   localparam int EW = 97 + IW;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   localparam logic [3:0] B_CLR  = 4'd0;
   localparam logic [3:0] B_IDLE = 4'd1;
   localparam logic [3:0] F_RD   = 4'd2;
   localparam logic [3:0] F_EV   = 4'd3;
   localparam logic [3:0] P_RD   = 4'd4;
   localparam logic [3:0] P_EV   = 4'd5;
   localparam logic [3:0] E_RD   = 4'd6;
   localparam logic [3:0] E_EV   = 4'd7;
   localparam logic [3:0] E_CLR  = 4'd8;
   localparam logic [3:0] B_OUT  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] nxt_ff, nxt_in;
   logic [IW-1:0] home_ff, home_in;
   logic [IW:0]   dist_ff, dist_in;
   logic [63:0]   key_ff, key_in;
   logic [31:0]   val_ff, val_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   vout_ff, vout_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          we;
   logic [IW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;

   req_type       q_req;
   logic [IW-1:0] q_home;

   logic          s_occ;
   logic [IW-1:0] s_dist;
   logic [31:0]   s_val;
   logic [63:0]   s_key;
   logic          f_stop, f_hit;
   logic [CW+ENT_W-1:0] count_wide;

   rhht_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (ra),
      .rd_data (rd)
   );

   assign q_req = pop_data[$bits(req_type)-1:0];
   assign q_home = pop_data[$bits(req_type)+IW-1:$bits(req_type)];

   assign s_occ = rd[OCC_BIT];
   assign s_dist = rd[OCC_BIT-1:DIST_LO];
   assign s_val = rd[DIST_LO-1:VAL_LO];
   assign s_key = rd[VAL_LO-1:0];

   // probe bound reached, empty slot, or a richer slot ends the search
   assign f_stop = dist_ff[IW] || !s_occ || ({1'b0, s_dist} < dist_ff);
   assign f_hit = !f_stop && (s_key == key_ff);

   assign count_wide = {{ENT_W{1'b0}}, count_ff};

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      nxt_in = nxt_ff;
      home_in = home_ff;
      dist_in = dist_ff;
      key_in = key_ff;
      val_in = val_ff;
      cmd_in = cmd_ff;
      count_in = count_ff;
      status_in = status_ff;
      vout_in = vout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pop_ready = 1'b0;
      we = 1'b0;
      wa = pos_ff;
      wd = '0;
      ra = pos_ff;
      unique case (state_ff)
         B_CLR: begin
            we = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (&pos_ff) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in = q_req.cmd;
               key_in = {q_req.x_coord, q_req.z_coord};
               val_in = q_req.value_in;
               home_in = q_home;
               pos_in = q_home;
               dist_in = '0;
               vout_in = '0;
               state_in = F_RD;
            end
         end
         F_RD: begin
            state_in = F_EV;
         end
         F_EV: begin
            if (f_hit || f_stop) begin
               state_in = B_OUT;
               priority if (cmd_ff == CMD_INSERT) begin
                  if (f_hit) begin
                     we = 1'b1;
                     wd = {1'b1, s_dist, val_ff, s_key};
                     status_in = ST_UPDATED;
                  end else if (count_ff == CAP_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     pos_in = home_ff;
                     dist_in = '0;
                     state_in = P_RD;
                  end
               end else if (cmd_ff == CMD_REMOVE) begin
                  if (f_hit) begin
                     nxt_in = pos_ff + 1'b1;
                     dist_in = (IW + 1)'(1);
                     state_in = E_RD;
                  end else begin
                     status_in = ST_MISSING;
                  end
               end else begin
                  status_in = f_hit ? ST_FOUND : ST_MISSING;
                  vout_in = f_hit ? s_val : 32'd0;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
               dist_in = dist_ff + 1'b1;
               state_in = F_RD;
            end
         end
         P_RD: begin
            state_in = P_EV;
         end
         P_EV: begin
            // key_ff, val_ff and dist_ff carry the entry being placed
            if (!s_occ) begin
               we = 1'b1;
               wd = {1'b1, dist_ff[IW-1:0], val_ff, key_ff};
               count_in = count_ff + 1'b1;
               status_in = ST_INSERTED;
               state_in = B_OUT;
            end else begin
               if ({1'b0, s_dist} < dist_ff) begin
                  we = 1'b1;
                  wd = {1'b1, dist_ff[IW-1:0], val_ff, key_ff};
                  key_in = s_key;
                  val_in = s_val;
                  dist_in = {1'b0, s_dist} + 1'b1;
               end else begin
                  dist_in = dist_ff + 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               state_in = P_RD;
            end
         end
         E_RD: begin
            ra = nxt_ff;
            state_in = dist_ff[IW] ? E_CLR : E_EV;
         end
         E_EV: begin
            // shift the displaced run back by one slot
            if (!s_occ || (s_dist == '0)) begin
               state_in = E_CLR;
            end else begin
               we = 1'b1;
               wd = {1'b1, s_dist - 1'b1, s_val, s_key};
               pos_in = nxt_ff;
               nxt_in = nxt_ff + 1'b1;
               dist_in = dist_ff + 1'b1;
               state_in = E_RD;
            end
         end
         E_CLR: begin
            we = 1'b1;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            status_in = ST_REMOVED;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.value_out = vout_ff;
               rsp_in.entries_used = count_wide[ENT_W-1:0];
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign clearing = (state_ff == B_CLR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLR;
         pos_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff <= nxt_in;
      home_ff <= home_in;
      dist_ff <= dist_in;
      key_ff <= key_in;
      val_ff <= val_in;
      cmd_ff <= cmd_in;
      status_ff <= status_in;
      vout_ff <= vout_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- hw/rtl/robin_hood_hash_table.sv -----
// Robin Hood hash table keyed by {x_coord, z_coord}, fixed power-of-two CAPACITY.
// After reset the slot memory is swept clear, slot by slot, with req_ready low. The
// front hashes a request word on one shared 32x32 multiplier and hands it through
// a two word queue to the back, which owns the single slot memory and spends a
// read state and then an evaluate state on each slot it probes. A lookup, update
// or missed remove walks only the search run from the home slot; an insert of a
// new key walks its search run and then a second run from the home slot to the
// first empty slot; a remove also shifts each following displaced entry back by
// one slot and then clears the freed slot. The back takes the word from the queue
// in its idle state and loads the result register in its output state; the hash
// of the next item overlaps the back end's work.
module robin_hood_hash_table import rhht_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int QW = $bits(req_type) + IW;
   localparam logic [31:0] CAP_VEC = 32'(CAPACITY);

   logic          clearing;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0] push_data, pop_data;

   rhht_front #(.IW(IW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rhht_queue #(.W(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rhht_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request taken during clearing pass");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL) |->
         rsp_data.entries_used == CAP_VEC[ENT_W-1:0])
      else $error("full status with free slots");

   a_value_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_FOUND) |-> rsp_data.value_out == 32'd0)
      else $error("nonzero handle on a word that is not a hit");

endmodule
